// File: hdl/tll_pkg.sv
`default_nettype none

package tll_pkg;

  // Widths of the fixed-point datapath
  localparam int unsigned PitchW   = 17;
  localparam int unsigned LiftW    = 16;
  localparam int unsigned EstW     = 32;
  localparam int unsigned EstFrac  = 14;
  localparam int unsigned CntW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MulAW    = 33;
  localparam int unsigned MulBW    = 17;
  localparam int unsigned MulPW    = MulAW + MulBW;

  localparam logic [CntW-1:0] CNT_SAT = 16'hFFFE;

  localparam int unsigned TILT_CONFIRM_DEF    = 100;
  localparam int unsigned SETTLE_CONFIRM_DEF  = 300;
  localparam int unsigned RELEASE_CONFIRM_DEF = 150;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_FILTER_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LIFT_FLOOR    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LIFT_CEILING  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LIFT_GAIN     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TILT_THR      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LEVEL_THR     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_RELEVEL_THR   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_BALANCE_LIMIT = 3'd7;

  typedef struct packed {
    logic        [15:0] filter_gain;
    logic signed [15:0] lift_floor;
    logic signed [15:0] lift_ceiling;
    logic        [7:0]  lift_gain;
    logic        [15:0] tilt_threshold;
    logic        [15:0] level_threshold;
    logic        [15:0] relevel_threshold;
    logic        [15:0] balance_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_LEVEL  = 2'd0,
    MODE_TILT   = 2'd1,
    MODE_SETTLE = 2'd2
  } mode_e;

endpackage

`default_nettype wire

// File: hdl/tll_mul.sv
`default_nettype none

module tll_mul (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [tll_pkg::MulAW-1:0]    a_i,
  input  wire logic signed [tll_pkg::MulBW-1:0]    b_i,
  output logic signed      [tll_pkg::MulPW-1:0]    prod_o
);

  logic signed [tll_pkg::MulPW-1:0] prod_q;
  logic signed [tll_pkg::MulPW-1:0] prod_d;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: hdl/tll_cfg.sv
`default_nettype none

module tll_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tll_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [tll_pkg::CfgDataW-1:0]      cfg_data_i,
  output tll_pkg::cfg_t                          cfg_o
);

  tll_pkg::cfg_t cfg_q;
  tll_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tll_pkg::REG_FILTER_GAIN:   cfg_d.filter_gain       = cfg_data_i;
        tll_pkg::REG_LIFT_FLOOR:    cfg_d.lift_floor        = cfg_data_i;
        tll_pkg::REG_LIFT_CEILING:  cfg_d.lift_ceiling      = cfg_data_i;
        tll_pkg::REG_LIFT_GAIN:     cfg_d.lift_gain         = cfg_data_i[7:0];
        tll_pkg::REG_TILT_THR:      cfg_d.tilt_threshold    = cfg_data_i;
        tll_pkg::REG_LEVEL_THR:     cfg_d.level_threshold   = cfg_data_i;
        tll_pkg::REG_RELEVEL_THR:   cfg_d.relevel_threshold = cfg_data_i;
        tll_pkg::REG_BALANCE_LIMIT: cfg_d.balance_limit     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_gain       <= 16'd3277;
      cfg_q.lift_floor        <= 16'sd0;
      cfg_q.lift_ceiling      <= 16'sd32767;
      cfg_q.lift_gain         <= 8'd12;
      cfg_q.tilt_threshold    <= 16'd2048;
      cfg_q.level_threshold   <= 16'd563;
      cfg_q.relevel_threshold <= 16'd1024;
      cfg_q.balance_limit     <= 16'd300;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hdl/tilt_leveling_lift_controller_top.sv
// Tilt-leveling lift controller, one request per control tick.
// Input channel: raw_pitch_i, active_i, front_feedback_i, back_feedback_i,
// qualified by in_valid_i; a request is taken at an edge with in_valid_i high
// and in_stall_o low. Output channel: front_target_o, back_target_o, mode_o,
// filtered_pitch_o, qualified by out_valid_o and held while out_stall_i.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at once.
// Each request steps through accept, filter multiply, estimate update,
// lift-gain multiply and mode/target update. A single registered
// 33x17 multiplier is shared by the filter and the lift gain, and the
// sequencer steps through it, so a new request is taken only after the
// last one has left the update step; in_stall_o stays high until then.
// The result sits in an output register; the next request is taken and
// processed while it waits, and only the final update step holds while the
// receiver still stalls an earlier result.
// Reset clears the pitch estimate, mode, counters and lift targets, and
// restores the register defaults; no result is pending after reset.
`default_nettype none

module tilt_leveling_lift_controller_top #(
  parameter int unsigned TILT_CONFIRM_TICKS    = tll_pkg::TILT_CONFIRM_DEF,
  parameter int unsigned SETTLE_CONFIRM_TICKS  = tll_pkg::SETTLE_CONFIRM_DEF,
  parameter int unsigned RELEASE_CONFIRM_TICKS = tll_pkg::RELEASE_CONFIRM_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [tll_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  wire logic [tll_pkg::CfgDataW-1:0]          cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [tll_pkg::PitchW-1:0]     raw_pitch_i,
  input  wire logic                                  active_i,
  input  wire logic signed [tll_pkg::LiftW-1:0]      front_feedback_i,
  input  wire logic signed [tll_pkg::LiftW-1:0]      back_feedback_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [tll_pkg::LiftW-1:0]           front_target_o,
  output logic signed [tll_pkg::LiftW-1:0]           back_target_o,
  output logic [1:0]                                 mode_o,
  output logic signed [tll_pkg::PitchW-1:0]          filtered_pitch_o
);

  localparam logic [tll_pkg::CntW-1:0] TiltLim    = tll_pkg::CntW'(TILT_CONFIRM_TICKS);
  localparam logic [tll_pkg::CntW-1:0] SettleLim  = tll_pkg::CntW'(SETTLE_CONFIRM_TICKS);
  localparam logic [tll_pkg::CntW-1:0] ReleaseLim = tll_pkg::CntW'(RELEASE_CONFIRM_TICKS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FILT = 5'b00010,
    S_EST  = 5'b00100,
    S_LIFT = 5'b01000,
    S_UPD  = 5'b10000
  } state_e;

  typedef logic signed [18:0] wide_t;

  function automatic logic signed [15:0] clamp_goal(input wide_t v,
                                                    input logic signed [15:0] lo,
                                                    input logic signed [15:0] hi);
    wide_t r;
    r = v;
    if (r < wide_t'(lo)) r = wide_t'(lo);
    if (r > wide_t'(hi)) r = wide_t'(hi);
    return r[15:0];
  endfunction

  tll_pkg::cfg_t cfg;

  tll_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  state_e state_q, state_d;

  // Request latch
  logic signed [tll_pkg::PitchW-1:0] raw_q;
  logic                              active_q;
  logic signed [tll_pkg::LiftW-1:0]  ffb_q, bfb_q;

  // Persistent controller state
  logic signed [tll_pkg::EstW-1:0] est_q, est_d;
  tll_pkg::mode_e                  mode_q, mode_d;
  logic [tll_pkg::CntW-1:0]        tilt_cnt_q, tilt_cnt_d;
  logic [tll_pkg::CntW-1:0]        settle_cnt_q, settle_cnt_d;
  logic [tll_pkg::CntW-1:0]        release_cnt_q, release_cnt_d;
  logic signed [15:0]              front_goal_q, front_goal_d;
  logic signed [15:0]              back_goal_q, back_goal_d;

  // Output register
  logic                              out_valid_q;
  logic signed [15:0]                front_out_q, back_out_q;
  logic [1:0]                        mode_out_q;
  logic signed [tll_pkg::PitchW-1:0] pitch_out_q;

  // Shared multiplier
  logic                                mul_en;
  logic signed [tll_pkg::MulAW-1:0]    mul_a;
  logic signed [tll_pkg::MulBW-1:0]    mul_b;
  logic signed [tll_pkg::MulPW-1:0]    mul_p;

  tll_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  logic signed [tll_pkg::PitchW-1:0] pitch;
  logic [16:0]                       pitch_mag;
  logic signed [17:0]                pitch_neg;
  logic signed [tll_pkg::MulAW-1:0]  filt_diff;
  logic signed [33:0]                est_sum;
  logic signed [24:0]                lift_prod;
  logic signed [25:0]                lift_neg;
  wide_t                             back_new, front_new;
  logic signed [16:0]                goal_diff;
  logic [16:0]                       goal_mag;
  logic                              upd_go;

  // The estimate (Q14 fraction) always stays inside the raw pitch range, so its integer part fits.
  assign pitch     = est_q[30:14];
  assign pitch_neg = -{pitch[16], pitch};
  assign pitch_mag = pitch[16] ? pitch_neg[16:0] : pitch[16:0];

  assign filt_diff = {{2{raw_q[16]}}, raw_q, 14'b0} - {est_q[31], est_q};
  assign est_sum   = {{2{est_q[31]}}, est_q} + mul_p[49:16];

  assign lift_prod = mul_p[24:0];
  assign lift_neg  = -{lift_prod[24], lift_prod};
  assign back_new  = wide_t'(lift_prod >>> 8) + wide_t'(bfb_q);
  assign front_new = wide_t'(lift_neg >>> 8) + wide_t'(ffb_q);

  assign goal_diff = {front_goal_q[15], front_goal_q} - {back_goal_q[15], back_goal_q};
  assign goal_mag  = goal_diff[16] ? 17'(-goal_diff) : 17'(goal_diff);

  assign upd_go = (state_q == S_UPD) && !(out_valid_q && out_stall_i);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = filt_diff;
    mul_b  = {1'b0, cfg.filter_gain};
    unique case (state_q)
      S_FILT: mul_en = 1'b1;
      S_LIFT: begin
        mul_en = 1'b1;
        mul_a  = tll_pkg::MulAW'(pitch);
        mul_b  = {9'b0, cfg.lift_gain};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_FILT;
      S_FILT: state_d = S_EST;
      S_EST:  state_d = S_LIFT;
      S_LIFT: state_d = S_UPD;
      S_UPD:  if (upd_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign est_d = est_sum[31:0];

  // Mode machine and lift goals
  always_comb begin
    wide_t fg, bg;
    fg            = wide_t'(front_goal_q);
    bg            = wide_t'(back_goal_q);
    mode_d        = mode_q;
    tilt_cnt_d    = tilt_cnt_q;
    settle_cnt_d  = settle_cnt_q;
    release_cnt_d = release_cnt_q;
    if (active_q) begin
      unique case (mode_q)
        tll_pkg::MODE_LEVEL: begin
          fg = wide_t'(cfg.lift_floor);
          bg = wide_t'(cfg.lift_floor);
          if ((pitch_mag > {1'b0, cfg.tilt_threshold}) && (tilt_cnt_q < tll_pkg::CNT_SAT)) begin
            tilt_cnt_d = tilt_cnt_q + 16'd1;
          end else begin
            tilt_cnt_d = '0;
          end
          if (tilt_cnt_d > TiltLim) begin
            mode_d     = tll_pkg::MODE_TILT;
            tilt_cnt_d = '0;
          end
        end
        tll_pkg::MODE_TILT: begin
          if (pitch > 17'sd0) begin
            if (front_goal_q <= cfg.lift_floor) bg = back_new;
            else fg = front_new;
          end else begin
            if (back_goal_q <= cfg.lift_floor) fg = front_new;
            else bg = back_new;
          end
          if ((pitch_mag < {1'b0, cfg.level_threshold}) &&
              (settle_cnt_q < tll_pkg::CNT_SAT)) begin
            settle_cnt_d = settle_cnt_q + 16'd1;
          end else begin
            settle_cnt_d = '0;
          end
          if (settle_cnt_d > SettleLim) begin
            mode_d       = tll_pkg::MODE_SETTLE;
            settle_cnt_d = '0;
          end
        end
        tll_pkg::MODE_SETTLE: begin
          // Going back to tilt keeps the release count
          if (pitch_mag > {1'b0, cfg.relevel_threshold}) begin
            mode_d = tll_pkg::MODE_TILT;
          end else if ((goal_mag < {1'b0, cfg.balance_limit}) &&
                       (release_cnt_q < tll_pkg::CNT_SAT)) begin
            release_cnt_d = release_cnt_q + 16'd1;
          end
          if (release_cnt_d > ReleaseLim) begin
            mode_d        = tll_pkg::MODE_LEVEL;
            release_cnt_d = '0;
          end
        end
        default: ;
      endcase
    end
    front_goal_d = clamp_goal(fg, cfg.lift_floor, cfg.lift_ceiling);
    back_goal_d  = clamp_goal(bg, cfg.lift_floor, cfg.lift_ceiling);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      est_q         <= '0;
      mode_q        <= tll_pkg::MODE_LEVEL;
      tilt_cnt_q    <= '0;
      settle_cnt_q  <= '0;
      release_cnt_q <= '0;
      front_goal_q  <= '0;
      back_goal_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EST) begin
        est_q <= est_d;
      end
      if (upd_go) begin
        mode_q        <= mode_d;
        tilt_cnt_q    <= tilt_cnt_d;
        settle_cnt_q  <= settle_cnt_d;
        release_cnt_q <= release_cnt_d;
        front_goal_q  <= front_goal_d;
        back_goal_q   <= back_goal_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      raw_q    <= raw_pitch_i;
      active_q <= active_i;
      ffb_q    <= front_feedback_i;
      bfb_q    <= back_feedback_i;
    end
    if (upd_go) begin
      front_out_q <= front_goal_d;
      back_out_q  <= back_goal_d;
      mode_out_q  <= mode_d;
      pitch_out_q <= pitch;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign front_target_o   = front_out_q;
  assign back_target_o    = back_out_q;
  assign mode_o           = mode_out_q;
  assign filtered_pitch_o = pitch_out_q;

endmodule

`default_nettype wire
